// File: rtl/core/bmp_stream_depadder_core_defines.svh
// ----------------------------------------------------------------------------
// bmp_stream_depadder_core_defines
// Assertion macros used by the depadder engine RTL.
// ----------------------------------------------------------------------------
`ifndef BMP_STREAM_DEPADDER_CORE_DEFINES_SVH
`define BMP_STREAM_DEPADDER_CORE_DEFINES_SVH

// same-cycle implication
`define BSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/bmp_sd_pkg.sv
// ----------------------------------------------------------------------------
// bmp_sd_pkg
// Types and constants for the bitmap stream depadder.
// ----------------------------------------------------------------------------
`default_nettype none

package bmp_sd_pkg;

  localparam int WIDTH_PIXELS = 128;
  localparam int HEIGHT_ROWS  = 296;

  localparam int ROW_BYTES = (WIDTH_PIXELS + 7) / 8;
  localparam int BUF_BYTES = ROW_BYTES * HEIGHT_ROWS;
  localparam int PAD_BYTES = (4 - (ROW_BYTES % 4)) % 4;

  localparam int ADDR_W = 13;
  localparam int BW_W   = $clog2(BUF_BYTES + 1);
  localparam int ROW_W  = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int PAD_W  = 2;
  localparam int HDR_W  = 32;

  localparam logic [7:0] CHAR_B = 8'h42;
  localparam logic [7:0] CHAR_M = 8'h4D;

  localparam logic [HDR_W-1:0] HDR_FIRST  = 32'd2;
  localparam logic [HDR_W-1:0] OFF_FIRST  = 32'd10;
  localparam logic [HDR_W-1:0] OFF_LAST   = 32'd13;
  localparam logic [HDR_W-1:0] WID_FIRST  = 32'd18;
  localparam logic [HDR_W-1:0] WID_LAST   = 32'd21;
  localparam logic [HDR_W-1:0] HGT_FIRST  = 32'd22;
  localparam logic [HDR_W-1:0] HGT_LAST   = 32'd25;
  localparam logic [HDR_W-1:0] HEADER_END = 32'd26;

  localparam logic [31:0] WIDTH_WORD  = 32'(WIDTH_PIXELS);
  localparam logic [31:0] HEIGHT_WORD = 32'(HEIGHT_ROWS);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_BUSY   = 2'd1,
    ST_DONE   = 2'd2,
    ST_REJECT = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } in_word_t;

  typedef struct packed {
    logic              write_valid;
    logic [ADDR_W-1:0] write_address;
    logic [7:0]        write_data;
    logic [1:0]        image_status;
    logic              last;
  } out_word_t;

endpackage

`default_nettype wire

// File: rtl/core/bmp_stream_depadder_core.sv
// A byte waits in the input register; the engine puts its result word in
// the output register. Throughput: one byte per cycle while the output
// has space; a held 'B' not followed by 'M' gives its own result word
// first. Both sides are registered; engine state updates only on fire.
// Reset (rst_n low, synchronous) empties both registers and returns the
// image status to not started.
// ----------------------------------------------------------------------------
// bmp_stream_depadder_core
// Bitmap byte stream header parser and row depadder, top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_stream_depadder_core
  import bmp_sd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  logic      item_valid;
  in_word_t  item;
  logic      retire;
  logic      push;
  logic      out_space;
  out_word_t result;

  bmp_sd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .retire     (retire),
    .item_valid (item_valid),
    .item       (item)
  );

  bmp_sd_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_space  (out_space),
    .retire     (retire),
    .push       (push),
    .result     (result)
  );

  bmp_sd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .result    (result),
    .out_space (out_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: rtl/core/bmp_sd_in_reg.sv
// ----------------------------------------------------------------------------
// bmp_sd_in_reg
// Input register holding one stream word until the engine retires it.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_sd_in_reg
  import bmp_sd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_data,
  input  wire logic     retire,
  output logic          item_valid,
  output in_word_t      item
);

  logic     valid_r;
  logic     valid_nxt;
  in_word_t data_r;

  assign in_ready   = !valid_r || retire;
  assign item_valid = valid_r;
  assign item       = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (retire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bmp_sd_engine.sv
// ----------------------------------------------------------------------------
// bmp_sd_engine
// Header parse, offset skip, row depad state; at most one result per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bmp_stream_depadder_core_defines.svh"

module bmp_sd_engine
  import bmp_sd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     item_valid,
  input  wire in_word_t item,
  input  wire logic     out_space,
  output logic          retire,
  output logic          push,
  output out_word_t     result
);

  status_t           status_r,  status_nxt;
  logic [BW_W-1:0]   bw_r,      bw_nxt;
  logic [ROW_W-1:0]  row_r,     row_nxt;
  logic [PAD_W-1:0]  pad_r,     pad_nxt;
  logic [HDR_W-1:0]  hdr_r,     hdr_nxt;
  logic [31:0]       offset_r,  offset_nxt;
  logic              mism_r,    mism_nxt;
  logic              held_r,    held_nxt;

  logic              fire;
  logic              push_req;
  logic              done_item;
  logic [7:0]        cbyte;
  logic              do_consume;
  logic              is_restart;
  logic              is_hold;
  logic [1:0]        shift_idx;
  logic [4:0]        shift_amt;
  logic [7:0]        width_ref;
  logic [7:0]        height_ref;
  logic [HDR_W-1:0]  hdr_inc;
  logic              wr_valid;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              res_last;

  assign shift_idx  = 2'(hdr_r[1:0] - 2'd2);
  assign shift_amt  = {shift_idx, 3'b000};
  assign width_ref  = 8'(WIDTH_WORD >> shift_amt);
  assign height_ref = 8'(HEIGHT_WORD >> shift_amt);
  assign hdr_inc    = hdr_r + 32'd1;

  always_comb begin
    is_restart = 1'b0;
    is_hold    = 1'b0;
    do_consume = 1'b0;
    cbyte      = item.data_byte;
    if (held_r) begin
      if (!item.packet_start && item.data_byte == CHAR_M && status_r != ST_REJECT) begin
        is_restart = 1'b1;
      end else begin
        do_consume = 1'b1;
        cbyte      = CHAR_B;
      end
    end else if (item.packet_start && item.data_byte == CHAR_B && status_r != ST_REJECT) begin
      is_hold = 1'b1;
    end else begin
      do_consume = 1'b1;
    end
  end

  always_comb begin
    status_nxt = status_r;
    bw_nxt     = bw_r;
    row_nxt    = row_r;
    pad_nxt    = pad_r;
    hdr_nxt    = hdr_r;
    offset_nxt = offset_r;
    mism_nxt   = mism_r;
    wr_valid   = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    if (is_restart) begin
      status_nxt = ST_BUSY;
      bw_nxt     = '0;
      row_nxt    = '0;
      pad_nxt    = '0;
      hdr_nxt    = HDR_FIRST;
      offset_nxt = '0;
      mism_nxt   = 1'b0;
    end else if (do_consume && status_r != ST_REJECT) begin
      if (hdr_r != '0) begin
        if (hdr_r inside {[OFF_FIRST:OFF_LAST]}) begin
          offset_nxt = offset_r | (32'(cbyte) << shift_amt);
        end else if (hdr_r inside {[WID_FIRST:WID_LAST]}) begin
          if (cbyte != width_ref) begin
            mism_nxt = 1'b1;
          end
        end else if (hdr_r inside {[HGT_FIRST:HGT_LAST]}) begin
          if (cbyte != height_ref) begin
            mism_nxt = 1'b1;
          end
        end
        if (hdr_r == HGT_LAST && mism_nxt) begin
          status_nxt = ST_REJECT;
          hdr_nxt    = '0;
        end else if (hdr_inc >= HEADER_END && hdr_inc >= offset_nxt) begin
          hdr_nxt = '0;
        end else begin
          hdr_nxt = hdr_inc;
        end
      end else if (pad_r != '0) begin
        pad_nxt = pad_r - 1'b1;
      end else if (bw_r >= BW_W'(BUF_BYTES)) begin
        status_nxt = ST_REJECT;
      end else begin
        wr_valid = 1'b1;
        wr_addr  = ADDR_W'(bw_r);
        wr_data  = cbyte;
        bw_nxt   = BW_W'(bw_r + 1'b1);
        if (row_r == ROW_W'(ROW_BYTES - 1)) begin
          row_nxt = '0;
          pad_nxt = PAD_W'(PAD_BYTES);
        end else begin
          row_nxt = ROW_W'(row_r + 1'b1);
        end
        if (bw_nxt == BW_W'(BUF_BYTES)) begin
          status_nxt = ST_DONE;
        end
      end
    end
  end

  always_comb begin
    held_nxt  = held_r;
    done_item = 1'b1;
    res_last  = 1'b1;
    if (is_hold) begin
      held_nxt = 1'b1;
    end else if (held_r && !is_restart) begin
      held_nxt  = item.packet_start && item.data_byte == CHAR_B && status_nxt != ST_REJECT;
      done_item = held_nxt;
      res_last  = held_nxt;
    end else if (held_r) begin
      held_nxt = 1'b0;
    end
  end

  assign push_req = !is_hold;
  assign fire     = item_valid && (out_space || !push_req);
  assign push     = fire && push_req;
  assign retire   = fire && done_item;

  always_comb begin
    result.write_valid   = wr_valid;
    result.write_address = wr_addr;
    result.write_data    = wr_data;
    result.image_status  = status_nxt;
    result.last          = res_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= ST_IDLE;
      bw_r     <= '0;
      row_r    <= '0;
      pad_r    <= '0;
      hdr_r    <= '0;
      offset_r <= '0;
      mism_r   <= 1'b0;
      held_r   <= 1'b0;
    end else if (fire) begin
      status_r <= status_nxt;
      bw_r     <= bw_nxt;
      row_r    <= row_nxt;
      pad_r    <= pad_nxt;
      hdr_r    <= hdr_nxt;
      offset_r <= offset_nxt;
      mism_r   <= mism_nxt;
      held_r   <= held_nxt;
    end
  end

  `BSD_ASSERT_IMP(a_addr_in_range, clk, rst_n, push && result.write_valid,
                  bw_r < BW_W'(BUF_BYTES), "write beyond frame buffer")
  `BSD_ASSERT_NXT(a_reject_sticky, clk, rst_n, status_r == ST_REJECT,
                  status_r == ST_REJECT, "rejected status left")
  `BSD_ASSERT_IMP(a_no_write_in_hdr, clk, rst_n, push && result.write_valid,
                  hdr_r == '0 && pad_r == '0, "pixel write during header or padding")
  `BSD_ASSERT_IMP(a_pad_at_row_start, clk, rst_n, pad_r != '0,
                  row_r == '0, "padding pending mid-row")

endmodule

`default_nettype wire

// File: rtl/core/bmp_sd_out_reg.sv
// ----------------------------------------------------------------------------
// bmp_sd_out_reg
// Result register; holds a word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_sd_out_reg
  import bmp_sd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire out_word_t result,
  output logic           out_space,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  logic      valid_r;
  logic      valid_nxt;
  out_word_t data_r;

  assign out_space = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (push) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= result;
    end
  end

endmodule

`default_nettype wire

// File: test/bmp_depad_checker.sv
// ----------------------------------------------------------------------------
// bmp_depad_checker
// Watches both channels of the bitmap depadder, tracks the header parser and
// row writer state from the accepted bytes, and compares every result word
// field by field with the oldest predicted word.
// ----------------------------------------------------------------------------
module bmp_depad_checker
  import bmp_sd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_data,
  output int        fail_count,
  output int        words_due,
  output int        words_checked,
  output int        pixel_writes,
  output int        header_restarts,
  output status_t   image_state
);
  timeunit 1ns;
  timeprecision 1ps;

  status_t          img_status = ST_IDLE;
  logic [BW_W-1:0]  written;
  logic [ROW_W:0]   row_pos;
  logic [PAD_W-1:0] pad_left;
  logic [HDR_W-1:0] hdr_pos;
  logic [31:0]      pix_offset;
  logic             size_bad;
  logic             b_held;

  out_word_t buffer_writes_due[$];

  int fails    = 0;
  int due_cnt  = 0;
  int checked  = 0;
  int writes   = 0;
  int restarts = 0;

  assign fail_count      = fails;
  assign words_due       = due_cnt;
  assign words_checked   = checked;
  assign pixel_writes    = writes;
  assign header_restarts = restarts;
  assign image_state     = img_status;

  function automatic void clear_parser();
    img_status = ST_IDLE;
    written    = '0;
    row_pos    = '0;
    pad_left   = '0;
    hdr_pos    = '0;
    pix_offset = '0;
    size_bad   = 1'b0;
    b_held     = 1'b0;
  endfunction

  function automatic void restart_header();
    img_status = ST_BUSY;
    written    = '0;
    row_pos    = '0;
    pad_left   = '0;
    hdr_pos    = HDR_FIRST;
    pix_offset = '0;
    size_bad   = 1'b0;
    restarts++;
  endfunction

  function automatic void parse_header(input logic [7:0] b);
    logic [HDR_W-1:0] p;
    int               sh;
    p  = hdr_pos;
    sh = 8 * int'((p - HDR_FIRST) & 32'd3);
    if (p >= OFF_FIRST && p <= OFF_LAST) begin
      pix_offset = pix_offset | (32'(b) << sh);
    end else if (p >= WID_FIRST && p <= WID_LAST) begin
      if (b != 8'(WIDTH_WORD >> sh)) size_bad = 1'b1;
    end else if (p >= HGT_FIRST && p <= HGT_LAST) begin
      if (b != 8'(HEIGHT_WORD >> sh)) size_bad = 1'b1;
    end
    if (p == HGT_LAST && size_bad) begin
      img_status = ST_REJECT;
      hdr_pos    = '0;
    end else if (p + 1 >= HEADER_END && p + 1 >= pix_offset) begin
      hdr_pos = '0;
    end else begin
      hdr_pos = p + 1;
    end
  endfunction

  function automatic out_word_t take_byte(input logic [7:0] b);
    out_word_t r;
    r = '0;
    if (img_status == ST_REJECT) begin
    end else if (hdr_pos != '0) begin
      parse_header(b);
    end else if (pad_left > 0) begin
      pad_left = pad_left - 1'b1;
    end else if (written >= BUF_BYTES) begin
      img_status = ST_REJECT;
    end else begin
      r.write_valid   = 1'b1;
      r.write_address = ADDR_W'(written);
      r.write_data    = b;
      written         = written + 1'b1;
      row_pos         = row_pos + 1'b1;
      if (row_pos >= ROW_BYTES) begin
        row_pos  = '0;
        pad_left = PAD_W'(PAD_BYTES);
      end
      if (written == BUF_BYTES) img_status = ST_DONE;
    end
    r.image_status = img_status;
    return r;
  endfunction

  function automatic void parse_stream_byte(input in_word_t w);
    out_word_t slot[2];
    int        n;
    n = 0;
    if (b_held && !w.packet_start && w.data_byte == CHAR_M && img_status != ST_REJECT) begin
      b_held = 1'b0;
      restart_header();
      slot[0] = '0;
      slot[0].image_status = img_status;
      n = 1;
    end else begin
      if (b_held) begin
        b_held  = 1'b0;
        slot[n] = take_byte(CHAR_B);
        n++;
      end
      if (w.packet_start && w.data_byte == CHAR_B && img_status != ST_REJECT) begin
        b_held = 1'b1;
      end else begin
        slot[n] = take_byte(w.data_byte);
        n++;
      end
    end
    if (n > 0) slot[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) buffer_writes_due.push_back(slot[i]);
  endfunction

  function automatic void compare_word(input out_word_t want, input out_word_t got);
    if (got !== want) begin
      fails++;
      if (got.write_valid !== want.write_valid)
        $display("%0t: write_valid expected %0d actual %0d", $time,
                 want.write_valid, got.write_valid);
      if (got.write_address !== want.write_address)
        $display("%0t: write_address expected %0d actual %0d", $time,
                 want.write_address, got.write_address);
      if (got.write_data !== want.write_data)
        $display("%0t: write_data expected %h actual %h", $time,
                 want.write_data, got.write_data);
      if (got.image_status !== want.image_status)
        $display("%0t: image_status expected %0d actual %0d", $time,
                 want.image_status, got.image_status);
      if (got.last !== want.last)
        $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
    end
  endfunction

  always @(posedge clk) begin
    out_word_t head;
    if (!rst_n) begin
      clear_parser();
      buffer_writes_due.delete();
    end else begin
      if (in_valid && in_ready) parse_stream_byte(in_data);
      if (out_valid && out_ready) begin
        if (buffer_writes_due.size() == 0) begin
          fails++;
          $display("%0t: result word expected none actual %h", $time, out_data);
        end else begin
          head = buffer_writes_due.pop_front();
          compare_word(head, out_data);
          checked++;
          if (out_data.write_valid === 1'b1) writes++;
        end
      end
    end
    due_cnt = buffer_writes_due.size();
  end

endmodule

// File: test/tb_bmp_stream_depadder_core.sv
// ----------------------------------------------------------------------------
// tb_bmp_stream_depadder_core
// Drives bitmap byte streams into the depadder core: headers with short and
// long pixel offsets, cut-off and broken headers, held 'B' cases and a final
// rejection on a bad size field, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_bmp_stream_depadder_core;
  timeunit 1ns;
  timeprecision 1ps;
  import bmp_sd_pkg::*;

  localparam int RANDOM_BYTES    = 1060;
  localparam int CYCLE_LIMIT     = 600_000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AFTER  = 400;
  localparam int DRAIN_CYCLES    = 16;
  localparam int HEADER_FIELDS   = int'(HEADER_END - HDR_FIRST);

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_LIGHT,
    RX_HEAVY
  } rx_mode_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  int      fail_count;
  int      words_due;
  int      words_checked;
  int      pixel_writes;
  int      header_restarts;
  status_t image_state;

  in_word_t byte_stream[$];
  int       bytes_sent  = 0;
  int       cycle_count = 0;

  rx_mode_t stall_mode = RX_STEADY;
  int       mode_left  = 0;
  int       hold_left  = 0;
  logic     hold_done  = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  bmp_stream_depadder_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  bmp_depad_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .words_due       (words_due),
    .words_checked   (words_checked),
    .pixel_writes    (pixel_writes),
    .header_restarts (header_restarts),
    .image_state     (image_state)
  );

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) bytes_sent <= bytes_sent + 1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_sent >= HOLD_OFF_AFTER) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_OFF_CYCLES;
      hold_done <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= rx_mode_t'($urandom_range(0, 2));
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        RX_STEADY: out_ready <= 1'b1;
        RX_LIGHT:  out_ready <= ($urandom_range(0, 3) != 0);
        default:   out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // a start flag on a plain 'B' would be held; drop the flag unless asked
  task automatic add_byte(input logic [7:0] d, input logic ps, input bit as_is);
    in_word_t w;
    w.data_byte    = d;
    w.packet_start = (!as_is && d == CHAR_B) ? 1'b0 : ps;
    byte_stream.push_back(w);
  endtask

  task automatic add_fill(input int n);
    for (int i = 0; i < n; i++)
      add_byte(8'($urandom), ($urandom_range(0, 5) == 0), 1'b0);
  endtask

  task automatic add_header(input logic [31:0] offset, input logic [31:0] wid,
                            input logic [31:0] hgt, input int n_fields);
    logic [7:0] d;
    add_byte(CHAR_B, 1'b1, 1'b1);
    add_byte(CHAR_M, 1'b0, 1'b1);
    for (int p = int'(HDR_FIRST); p < int'(HDR_FIRST) + n_fields; p++) begin
      d = 8'($urandom);
      if (p >= int'(OFF_FIRST) && p <= int'(OFF_LAST))
        d = 8'(offset >> (8 * (p - int'(OFF_FIRST))));
      else if (p >= int'(WID_FIRST) && p <= int'(WID_LAST))
        d = 8'(wid >> (8 * (p - int'(WID_FIRST))));
      else if (p >= int'(HGT_FIRST) && p <= int'(HGT_LAST))
        d = 8'(hgt >> (8 * (p - int'(HGT_FIRST))));
      add_byte(d, ($urandom_range(0, 5) == 0), 1'b0);
    end
  endtask

  task automatic add_image(input logic [31:0] offset, input int n_pixels);
    add_header(offset, WIDTH_WORD, HEIGHT_WORD, HEADER_FIELDS);
    add_fill(((offset > HEADER_END) ? int'(offset - HEADER_END) : 0) + n_pixels);
  endtask

  function automatic logic [31:0] pick_offset();
    case ($urandom_range(0, 9))
      0, 1, 2: return 32'($urandom_range(0, int'(HEADER_END)));
      9:       return 32'($urandom_range(200, 400));
      default: return 32'($urandom_range(int'(HEADER_END) + 1, 80));
    endcase
  endfunction

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run stopped after %0d cycles", $time, CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int         directed_len;
    int         burst_left;
    int         gap_len;
    logic [7:0] d;
    logic       ps;

    // pixel bytes before any header, then held 'B' cases
    add_byte(8'h00, 1'b1, 1'b1);
    add_byte(8'hFF, 1'b0, 1'b1);
    add_byte(CHAR_B, 1'b0, 1'b1);
    add_byte(CHAR_M, 1'b0, 1'b1);
    add_byte(CHAR_B, 1'b1, 1'b1);
    add_byte(8'hA5, 1'b0, 1'b1);
    add_byte(CHAR_B, 1'b1, 1'b1);
    add_byte(CHAR_B, 1'b1, 1'b1);
    add_byte(CHAR_M, 1'b1, 1'b1);
    add_byte(CHAR_B, 1'b1, 1'b1);
    add_byte(CHAR_M, 1'b0, 1'b1);
    add_byte(8'h7F, 1'b0, 1'b1);
    add_byte(8'h80, 1'b1, 1'b1);
    add_byte(8'h00, 1'b0, 1'b1);
    add_byte(8'hFF, 1'b1, 1'b1);
    directed_len = byte_stream.size();

    add_image(pick_offset(), $urandom_range(0, 60));
    while (byte_stream.size() < directed_len + RANDOM_BYTES) begin
      case ($urandom_range(0, 9))
        0: begin
          add_header($urandom, $urandom, $urandom, $urandom_range(0, HEADER_FIELDS - 1));
          add_image(pick_offset(), $urandom_range(0, 60));
        end
        1: begin
          add_header({8'($urandom_range(1, 255)), 24'($urandom)}, WIDTH_WORD, HEIGHT_WORD,
                     HEADER_FIELDS);
          add_fill($urandom_range(5, 40));
          add_image(pick_offset(), $urandom_range(0, 60));
        end
        2, 3: begin
          case ($urandom_range(0, 3))
            0: begin
              d  = 8'($urandom);
              ps = 1'($urandom_range(0, 1));
              if (d == CHAR_M) ps = 1'b1;
              add_byte(CHAR_B, 1'b1, 1'b1);
              add_byte(d, ps, 1'b0);
            end
            1: begin
              add_byte(CHAR_B, 1'b1, 1'b1);
              add_byte(CHAR_M, 1'b1, 1'b1);
            end
            2: begin
              add_byte(CHAR_B, 1'b0, 1'b1);
              add_byte(CHAR_M, 1'b0, 1'b1);
            end
            default: add_fill($urandom_range(1, 8));
          endcase
        end
        default: add_image(pick_offset(), $urandom_range(0, 60));
      endcase
    end

    // reject by a bad size field, then show the rejection holds
    if ($urandom_range(0, 1) == 0) begin
      add_header(32'd30, WIDTH_WORD ^ (32'd1 << $urandom_range(0, 31)), HEIGHT_WORD,
                 HEADER_FIELDS);
    end else begin
      add_header(32'd30, WIDTH_WORD, HEIGHT_WORD ^ (32'd1 << $urandom_range(0, 31)),
                 HEADER_FIELDS);
    end
    add_byte(CHAR_B, 1'b1, 1'b1);
    add_byte(CHAR_M, 1'b0, 1'b1);
    add_fill(20);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    burst_left = 0;
    while (byte_stream.size() > 0) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                 : $urandom_range(1, 32);
        gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap_len > 0) begin
          in_valid <= 1'b0;
          repeat (gap_len) @(posedge clk);
        end
      end
      in_valid <= 1'b1;
      in_data  <= byte_stream.pop_front();
      burst_left--;
      do @(posedge clk); while (!in_ready);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d stream bytes; checked %0d result words, %0d of them pixel writes.",
             bytes_sent, words_checked, pixel_writes);
    $display("Header restarts seen: %0d; image status at the end: %s.",
             header_restarts, image_state.name());
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: bmp_stream_depadder_core.f
+incdir+rtl/core
rtl/core/bmp_sd_pkg.sv
rtl/core/bmp_sd_in_reg.sv
rtl/core/bmp_sd_engine.sv
rtl/core/bmp_sd_out_reg.sv
rtl/core/bmp_stream_depadder_core.sv
test/bmp_depad_checker.sv
test/tb_bmp_stream_depadder_core.sv
